// File: hw/rtl/cb64_pkg.sv
`default_nettype none

package cb64_pkg;

	// Request actions
	localparam logic ACT_CHAR = 1'b0;
	localparam logic ACT_END  = 1'b1;

	// Configuration register indexes
	localparam int          CFG_INDEX_W   = 1;
	localparam logic [0:0]  CFG_MAX_ENC   = 1'b0;
	localparam logic [0:0]  CFG_MAX_DEC   = 1'b1;
	localparam int          CFG_DATA_W    = 16;

	localparam logic [15:0] MAX_ENC_RESET = 16'd4096;
	localparam logic [15:0] MAX_DEC_RESET = 16'd3072;

	// Character set
	localparam logic [7:0]  PAD_CHAR      = 8'h3D; // '='
	localparam logic [7:0]  PLUS_CHAR     = 8'h2B; // '+'
	localparam logic [7:0]  SLASH_CHAR    = 8'h2F; // '/'
	localparam logic [5:0]  PLUS_VALUE    = 6'd62;
	localparam logic [5:0]  SLASH_VALUE   = 6'd63;
	localparam logic [5:0]  LOWER_BASE    = 6'd26;
	localparam logic [5:0]  DIGIT_BASE    = 6'd52;

	// Unused-bit masks for one and two pad characters
	localparam logic [5:0]  PAD1_MASK     = 6'h03;
	localparam logic [5:0]  PAD2_MASK     = 6'h0F;

	localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

	typedef struct packed {
		logic       action;
		logic [7:0] symbol;
	} req_t;

	typedef struct packed {
		logic        is_valid;
		logic [15:0] byte_count;
	} rsp_t;

	typedef struct packed {
		logic       is_pad;
		logic       is_data;
		logic [5:0] value;
	} sym_class_t;

endpackage

`default_nettype wire

// File: hw/rtl/canonical_base64_validator_core.sv
`default_nettype none

// Streaming strict base64 checker, standard alphabet with '=' padding.
// Request channel (req_valid / req_stall / req): one item per string character
// (action = char) and one closing item (action = end). Character items give no
// response; each end item gives exactly one response on rsp_valid / rsp_stall /
// rsp carrying is_valid and byte_count (zero when the string is rejected).
// An end item leaves the request register, then its response loads the response
// register and shows on rsp. Throughput: one request per cycle unless req_stall,
// set by the single request and response registers; char checks are combinational.
// Stall: while a response waits under rsp_stall, character requests still flow;
// an end request waits in the request register, and req_stall rises only then.
// Reset (arst_n low): limits return to 4096 and 3072 characters/bytes, string
// state clears, both channels go empty. String state clears again after every
// end item. cfg_we writes limit cfg_index with cfg_data; write only when idle.
module canonical_base64_validator_core (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              req_valid,
	output      logic                              req_stall,
	input  wire cb64_pkg::req_t                    req,
	output      logic                              rsp_valid,
	input  wire logic                              rsp_stall,
	output      cb64_pkg::rsp_t                    rsp,
	input  wire logic                              cfg_we,
	input  wire logic [cb64_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [cb64_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import cb64_pkg::*;

	// Configuration
	logic [15:0] max_enc_q;
	logic [15:0] max_dec_q;

	// Request register
	logic        valid_s1;
	req_t        req_s1;

	// String state
	logic [15:0] char_count_q;
	logic        bad_char_q;
	logic        pad_misplaced_q;
	logic [1:0]  pad_run_q;
	logic [5:0]  last_data_q;

	// Response register
	logic        rsp_valid_q;
	rsp_t        rsp_q;

	sym_class_t  cls;
	logic        blocked;
	logic        advance;
	logic        end_adv;
	logic        char_adv;
	logic        len_ok;
	logic        pad_ok;
	logic [15:0] size;
	logic        size_ok;
	logic        ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_enc_q <= MAX_ENC_RESET;
			max_dec_q <= MAX_DEC_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAX_ENC: max_enc_q <= cfg_data;
				CFG_MAX_DEC: max_dec_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// An end request cannot leave the request register while the response
	// register holds an unread response.
	assign blocked   = (req_s1.action == ACT_END) && rsp_valid_q && rsp_stall;
	assign req_stall = valid_s1 && blocked;
	assign advance   = valid_s1 && !blocked;
	assign end_adv   = advance && (req_s1.action == ACT_END);
	assign char_adv  = advance && (req_s1.action == ACT_CHAR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
	end

	cb64_sym_decode u_decode (
		.symbol (req_s1.symbol),
		.cls    (cls)
	);

	// Update the string state on a character; clear it on end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_count_q    <= '0;
			bad_char_q      <= 1'b0;
			pad_misplaced_q <= 1'b0;
			pad_run_q       <= '0;
			last_data_q     <= '0;
		end else if (end_adv) begin
			char_count_q    <= '0;
			bad_char_q      <= 1'b0;
			pad_misplaced_q <= 1'b0;
			pad_run_q       <= '0;
			last_data_q     <= '0;
		end else if (char_adv) begin
			if (char_count_q != COUNT_MAX) begin
				char_count_q <= char_count_q + 16'd1;
			end
			if (cls.is_pad) begin
				// A third pad in a run is misplaced; hold the run at two.
				if (pad_run_q >= 2'd2) begin
					pad_misplaced_q <= 1'b1;
				end else begin
					pad_run_q <= pad_run_q + 2'd1;
				end
			end else if (cls.is_data) begin
				// Data after a pad breaks the final-run rule.
				if (pad_run_q != 2'd0) begin
					pad_misplaced_q <= 1'b1;
				end
				last_data_q <= cls.value;
			end else begin
				bad_char_q <= 1'b1;
			end
		end
	end

	// End-of-string checks
	always_comb begin
		len_ok = (char_count_q != 16'd0) && (char_count_q <= max_enc_q)
			&& (char_count_q[1:0] == 2'd0);
		case (pad_run_q)
			2'd1:    pad_ok = ((last_data_q & PAD1_MASK) == 6'd0);
			2'd2:    pad_ok = ((last_data_q & PAD2_MASK) == 6'd0);
			default: pad_ok = 1'b1;
		endcase
		// (len / 4) * 3 - pads; len / 4 tops out at 16383, so 16 bits hold it
		size    = {2'b00, char_count_q[15:2]} + {1'b0, char_count_q[15:2], 1'b0}
			- {14'd0, pad_run_q};
		size_ok = (size != 16'd0) && (size <= max_dec_q);
		ok      = len_ok && pad_ok && !bad_char_q && !pad_misplaced_q && size_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (end_adv) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (end_adv) begin
			rsp_q.is_valid   <= ok;
			rsp_q.byte_count <= ok ? size : 16'd0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// A new response appears only behind an end request in the request register.
	a_rsp_from_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(valid_s1 && (req_s1.action == ACT_END)))
		else $error("response without end request");

	// A rejected string reports size zero.
	a_reject_size: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp_q.is_valid) |-> (rsp_q.byte_count == 16'd0))
		else $error("rejected string with nonzero size");

	// State is clear after an end request leaves.
	a_clear_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		end_adv |=> (char_count_q == 16'd0) && (pad_run_q == 2'd0) && !bad_char_q)
		else $error("string state not cleared");

	// The pad run never exceeds two.
	a_pad_run: assert property (@(posedge clk) disable iff (!arst_n)
		pad_run_q != 2'd3)
		else $error("pad run overflow");

endmodule

`default_nettype wire

// File: hw/rtl/cb64_sym_decode.sv
`default_nettype none

module cb64_sym_decode (
	input  wire logic [7:0]          symbol,
	output      cb64_pkg::sym_class_t cls
);
	import cb64_pkg::*;

	logic [7:0] offs;

	always_comb begin
		offs        = 8'd0;
		cls.is_pad  = (symbol == PAD_CHAR);
		cls.is_data = 1'b0;
		cls.value   = 6'd0;
		if (symbol >= "A" && symbol <= "Z") begin
			offs        = symbol - 8'h41;
			cls.is_data = 1'b1;
			cls.value   = offs[5:0];
		end else if (symbol >= "a" && symbol <= "z") begin
			offs        = symbol - 8'h61;
			cls.is_data = 1'b1;
			cls.value   = LOWER_BASE + offs[5:0];
		end else if (symbol >= "0" && symbol <= "9") begin
			offs        = symbol - 8'h30;
			cls.is_data = 1'b1;
			cls.value   = DIGIT_BASE + offs[5:0];
		end else if (symbol == PLUS_CHAR) begin
			cls.is_data = 1'b1;
			cls.value   = PLUS_VALUE;
		end else if (symbol == SLASH_CHAR) begin
			cls.is_data = 1'b1;
			cls.value   = SLASH_VALUE;
		end
	end

endmodule

`default_nettype wire
